// ----- hdl/kaczmarz_linear_node_trainer_defines.svh -----
// assertion macros shared by the trainer checks
`ifndef KACZMARZ_LINEAR_NODE_TRAINER_DEFINES_SVH
`define KACZMARZ_LINEAR_NODE_TRAINER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define KLNT_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("klnt check failed");

// next-cycle implication, disabled in reset
`define KLNT_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("klnt check failed");

`endif

// ----- hdl/klnt_pkg.sv -----
// shared types, constants and arithmetic helpers of the linear node trainer
package klnt_pkg;

    localparam int N_FEATURES  = 8;
    localparam int MAX_SAMPLES = 256;

    localparam int FI_W  = (N_FEATURES > 1) ? $clog2(N_FEATURES) : 1;
    localparam int SC_W  = $clog2(MAX_SAMPLES + 1);
    localparam int TI_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SMP_DEPTH = MAX_SAMPLES * N_FEATURES;
    localparam int SA_W  = (SMP_DEPTH > 1) ? $clog2(SMP_DEPTH) : 1;

    localparam int POS_W   = 7;
    localparam int RATE_W  = 18;
    localparam int EPOCH_W = 16;
    localparam int RE_W    = 50;
    localparam int DVD_W   = 82;
    localparam int QW      = 34;
    localparam int DC_W    = $clog2(DVD_W);

    localparam logic [POS_W-1:0]  POS_MAX      = 7'd127;
    localparam logic [RATE_W-1:0] RATE_MAX     = 18'd131072;
    localparam logic [RATE_W-1:0] RATE_DEFAULT = 18'd32768;
    localparam logic [EPOCH_W-1:0] EPOCH_DEFAULT = 16'd1;
    localparam logic [QW-1:0]     DELTA_CAP    = 34'h2_0000_0000;
    localparam logic [31:0]       NEG_ONE_Q16  = 32'hFFFF_0000;

    localparam logic [1:0] OP_LOAD_W  = 2'd0;
    localparam logic [1:0] OP_LOAD_S  = 2'd1;
    localparam logic [1:0] OP_TRAIN   = 2'd2;
    localparam logic [1:0] OP_PREDICT = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_LEN_ERR = 2'd2;

    localparam logic CFG_RATE  = 1'b0;
    localparam logic CFG_EPOCH = 1'b1;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value;
        logic signed [31:0] target;
        logic               last;
    } in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [5:0]         weight_index;
        logic               result_last;
        logic [1:0]         status;
    } out_t;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    // q32.32 to q16.16, floor then saturate
    function automatic logic signed [31:0] q16_of_q32(input logic signed [63:0] a);
        logic signed [63:0] t;
        t = a >>> 16;
        if (t > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (t < -64'sd2147483648)
            return 32'sh8000_0000;
        return t[31:0];
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] a);
        return a[31] ? 32'(-a) : 32'(a);
    endfunction

endpackage

// ----- hdl/kaczmarz_linear_node_trainer.sv -----
// linear node trainer: kaczmarz updates on stored samples, prediction, weight load
// load items are taken in idle; a prediction element goes through multiply and accumulate states
// training runs the given epochs over the stored samples and then emits the weights through
// handshakes; the shared 32x32 multiplier and the one-bit-per-cycle divider set its
// pace. async active-low reset clears weights, counters and flags;
// the sample and target memories are not cleared and hold garbage until written
module kaczmarz_linear_node_trainer
    import klnt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_t                in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_t               out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [RATE_W-1:0]  cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_PM, S_PA, S_TSTART, S_DRD, S_DX, S_DM1, S_DA1, S_DM2, S_DA2,
        S_E1, S_E2, S_E3, S_URD, S_UX, S_UM1, S_UM2, S_USUM, S_UDV, S_UWR,
        S_NEXT, S_ELOAD, S_EMIT
    } state_t;

    state_t state_reg;

    logic [RATE_W-1:0]        learning_rate_reg;
    logic [EPOCH_W-1:0]       epoch_count_reg;
    logic [RATE_W-1:0]        rate_reg;
    logic signed [31:0]       w_reg [N_FEATURES];
    logic [SC_W-1:0]          sc_reg;
    logic [SA_W:0]            wbase_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [63:0]       pacc_reg;
    logic                     dropped_reg;

    logic [FI_W-1:0]          i_reg;
    logic [SC_W-1:0]          s_reg;
    logic [SA_W-1:0]          sbase_reg;
    logic [EPOCH_W-1:0]       ep_reg;
    logic [31:0]              ax_reg;
    logic                     xneg_reg;
    logic signed [31:0]       tgt_reg;
    logic signed [63:0]       acc_reg;
    logic [63:0]              norm_reg;
    logic                     neg_e_reg;
    logic [RE_W-1:0]          re_reg;
    logic [63:0]              plo_reg;
    logic [DVD_W-1:0]         dvd_reg;
    logic [63:0]              rem_reg;
    logic [QW-1:0]            q_reg;
    logic                     over_reg;
    logic [DC_W-1:0]          dcnt_reg;
    logic [POS_W-1:0]         pidx_reg;
    logic                     padd_reg;
    logic                     plast_reg;
    logic                     plen_ok_reg;
    logic                     train_emit_reg;
    logic                     out_valid_reg;
    out_t                     out_reg;

    // shared multiplier
    logic [31:0]              mul_a;
    logic [31:0]              mul_b;
    logic                     mul_neg;
    logic [63:0]              mul_q_reg;
    logic                     mul_neg_reg;
    logic signed [63:0]       sprod;

    // memories
    logic signed [31:0]       smem [SMP_DEPTH];
    logic signed [31:0]       tmem [MAX_SAMPLES];
    logic signed [31:0]       smem_q_reg;
    logic signed [31:0]       tmem_q_reg;
    logic                     smem_we;
    logic                     tmem_we;
    logic [SA_W-1:0]          smem_waddr;
    logic [SA_W-1:0]          smem_raddr;

    logic                     in_fire;
    logic [POS_W-1:0]         pos_inc;
    logic                     pos_in_range;
    logic                     room;
    logic [FI_W-1:0]          w_rd_idx;
    logic signed [31:0]       w_rd;
    logic [RATE_W-1:0]        rate_eff;

    logic signed [31:0]       y_q16;
    logic signed [32:0]       e_full;
    logic [32:0]              e_abs;
    logic [64:0]              norm_sum;
    logic signed [63:0]       pacc_new;
    logic [64:0]              rem_sh;
    logic                     rem_ge;
    logic [64:0]              rem_sub;
    logic                     q_capped;
    logic [QW-1:0]            q_mag;
    logic signed [QW:0]       delta;
    logic signed [35:0]       w_sum;
    logic signed [31:0]       w_sat;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign pos_inc      = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 1'b1;
    assign pos_in_range = (pos_reg < POS_W'(N_FEATURES));
    assign room         = (sc_reg < SC_W'(MAX_SAMPLES));
    assign rate_eff     = (learning_rate_reg > RATE_MAX) ? RATE_DEFAULT : learning_rate_reg;

    assign w_rd_idx = (state_reg == S_PM) ? pidx_reg[FI_W-1:0] : i_reg;
    assign w_rd     = w_reg[w_rd_idx];

    // operand selection for the one multiplier
    always_comb
    begin
        mul_a   = ax_reg;
        mul_b   = ax_reg;
        mul_neg = 1'b0;
        case (state_reg)
            S_PM, S_DM1:
            begin
                mul_a   = abs32(w_rd);
                mul_neg = w_rd[31] ^ xneg_reg;
            end
            S_E2:
            begin
                mul_a = 32'(rate_reg);
                mul_b = e_abs[31:0];
            end
            S_UM1:
                mul_a = re_reg[31:0];
            S_UM2:
                mul_a = 32'(re_reg[RE_W-1:32]);
            default:
                mul_a = ax_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_q_reg   <= mul_a * mul_b;
        mul_neg_reg <= mul_neg;
    end

    assign sprod = mul_neg_reg ? -$signed(mul_q_reg) : $signed(mul_q_reg);

    // error of the current sample
    assign y_q16  = q16_of_q32(acc_reg);
    assign e_full = {tgt_reg[31], tgt_reg} - {y_q16[31], y_q16};
    assign e_abs  = e_full[32] ? 33'(-e_full) : 33'(e_full);

    assign norm_sum = {1'b0, norm_reg} + {1'b0, mul_q_reg};
    assign pacc_new = padd_reg ? sat_add64(pacc_reg, sprod) : pacc_reg;

    // restoring divider step
    assign rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, norm_reg});
    assign rem_sub = rem_ge ? rem_sh - {1'b0, norm_reg} : rem_sh;

    // weight update from the final quotient
    assign q_capped = over_reg || (q_reg[QW-1] && (|q_reg[QW-2:0]));
    assign q_mag    = q_capped ? DELTA_CAP : q_reg;
    assign delta    = (neg_e_reg != xneg_reg) ? -$signed({1'b0, q_mag})
                                              : $signed({1'b0, q_mag});
    assign w_sum    = {{4{w_rd[31]}}, w_rd} + {delta[QW], delta};
    assign w_sat    = (w_sum > 36'sd2147483647)  ? 32'sh7FFF_FFFF :
                      (w_sum < -36'sd2147483648) ? 32'sh8000_0000 : w_sum[31:0];

    // sample and target memories
    assign smem_we    = in_fire && (in_data.operation == OP_LOAD_S) && room && pos_in_range;
    assign smem_waddr = SA_W'(wbase_reg + (SA_W + 1)'(pos_reg));
    assign tmem_we    = in_fire && (in_data.operation == OP_LOAD_S) && in_data.last &&
                        room && (pos_inc == POS_W'(N_FEATURES));
    assign smem_raddr = sbase_reg + SA_W'(i_reg);

    always_ff @(posedge clk)
    begin
        if (smem_we)
            smem[smem_waddr] <= in_data.value;
        smem_q_reg <= smem[smem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tmem_we)
            tmem[sc_reg[TI_W-1:0]] <= in_data.target;
        tmem_q_reg <= tmem[s_reg[TI_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            learning_rate_reg <= RATE_DEFAULT;
            epoch_count_reg   <= EPOCH_DEFAULT;
            rate_reg          <= RATE_DEFAULT;
            for (int k = 0; k < N_FEATURES; k++)
                w_reg[k] <= '0;
            sc_reg         <= '0;
            wbase_reg      <= '0;
            pos_reg        <= '0;
            pacc_reg       <= '0;
            dropped_reg    <= 1'b0;
            i_reg          <= '0;
            s_reg          <= '0;
            sbase_reg      <= '0;
            ep_reg         <= '0;
            ax_reg         <= '0;
            xneg_reg       <= 1'b0;
            tgt_reg        <= '0;
            acc_reg        <= '0;
            norm_reg       <= '0;
            neg_e_reg      <= 1'b0;
            re_reg         <= '0;
            plo_reg        <= '0;
            dvd_reg        <= '0;
            rem_reg        <= '0;
            q_reg          <= '0;
            over_reg       <= 1'b0;
            dcnt_reg       <= '0;
            pidx_reg       <= '0;
            padd_reg       <= 1'b0;
            plast_reg      <= 1'b0;
            plen_ok_reg    <= 1'b0;
            train_emit_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RATE:  learning_rate_reg <= cfg_data;
                    CFG_EPOCH: epoch_count_reg   <= cfg_data[EPOCH_W-1:0];
                    default:   learning_rate_reg <= learning_rate_reg;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        case (in_data.operation)
                            OP_LOAD_W:
                            begin
                                if (pos_in_range)
                                    w_reg[pos_reg[FI_W-1:0]] <= in_data.value;
                                pos_reg <= in_data.last ? '0 : pos_inc;
                            end
                            OP_LOAD_S:
                            begin
                                if (in_data.last)
                                begin
                                    if (room && (pos_inc == POS_W'(N_FEATURES)))
                                    begin
                                        sc_reg    <= sc_reg + 1'b1;
                                        wbase_reg <= wbase_reg + (SA_W + 1)'(N_FEATURES);
                                    end
                                    else
                                        dropped_reg <= 1'b1;
                                    pos_reg <= '0;
                                end
                                else
                                    pos_reg <= pos_inc;
                            end
                            OP_TRAIN:
                            begin
                                rate_reg  <= rate_eff;
                                state_reg <= S_TSTART;
                            end
                            default:
                            begin
                                ax_reg      <= abs32(in_data.value);
                                xneg_reg    <= in_data.value[31];
                                pidx_reg    <= pos_reg;
                                padd_reg    <= pos_in_range;
                                plast_reg   <= in_data.last;
                                plen_ok_reg <= (pos_inc == POS_W'(N_FEATURES));
                                pos_reg     <= in_data.last ? '0 : pos_inc;
                                state_reg   <= S_PM;
                            end
                        endcase
                    end
                end

                S_PM:
                    state_reg <= S_PA;

                S_PA:
                begin
                    if (plast_reg)
                    begin
                        out_reg.result_value <= plen_ok_reg ? q16_of_q32(pacc_new)
                                                            : NEG_ONE_Q16;
                        out_reg.status       <= plen_ok_reg ? ST_OK : ST_LEN_ERR;
                        out_reg.weight_index <= '0;
                        out_reg.result_last  <= 1'b1;
                        out_valid_reg        <= 1'b1;
                        train_emit_reg       <= 1'b0;
                        pacc_reg             <= '0;
                        state_reg            <= S_EMIT;
                    end
                    else
                    begin
                        pacc_reg  <= pacc_new;
                        state_reg <= S_IDLE;
                    end
                end

                S_TSTART:
                begin
                    ep_reg    <= '0;
                    s_reg     <= '0;
                    sbase_reg <= '0;
                    i_reg     <= '0;
                    acc_reg   <= '0;
                    norm_reg  <= '0;
                    if ((epoch_count_reg == '0) || (sc_reg == '0))
                        state_reg <= S_ELOAD;
                    else
                        state_reg <= S_DRD;
                end

                // dot product and squared norm, one element at a time
                S_DRD:
                    state_reg <= S_DX;

                S_DX:
                begin
                    ax_reg    <= abs32(smem_q_reg);
                    xneg_reg  <= smem_q_reg[31];
                    tgt_reg   <= tmem_q_reg;
                    state_reg <= S_DM1;
                end

                S_DM1:
                    state_reg <= S_DA1;

                S_DA1:
                begin
                    acc_reg   <= sat_add64(acc_reg, sprod);
                    state_reg <= S_DM2;
                end

                S_DM2:
                    state_reg <= S_DA2;

                S_DA2:
                begin
                    norm_reg <= norm_sum[64] ? {64{1'b1}} : norm_sum[63:0];
                    if (i_reg == FI_W'(N_FEATURES - 1))
                    begin
                        i_reg     <= '0;
                        state_reg <= S_E1;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_DRD;
                    end
                end

                S_E1:
                begin
                    neg_e_reg <= e_full[32];
                    // zero-norm sample is skipped
                    state_reg <= (norm_reg == '0) ? S_NEXT : S_E2;
                end

                S_E2:
                    state_reg <= S_E3;

                S_E3:
                begin
                    re_reg    <= mul_q_reg[RE_W-1:0];
                    state_reg <= S_URD;
                end

                // per-weight update: |rate*e*x| / norm
                S_URD:
                    state_reg <= S_UX;

                S_UX:
                begin
                    ax_reg    <= abs32(smem_q_reg);
                    xneg_reg  <= smem_q_reg[31];
                    state_reg <= S_UM1;
                end

                S_UM1:
                    state_reg <= S_UM2;

                S_UM2:
                begin
                    plo_reg   <= mul_q_reg;
                    state_reg <= S_USUM;
                end

                S_USUM:
                begin
                    dvd_reg   <= DVD_W'({mul_q_reg, 32'd0}) + DVD_W'(plo_reg);
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    over_reg  <= 1'b0;
                    dcnt_reg  <= '0;
                    state_reg <= S_UDV;
                end

                S_UDV:
                begin
                    rem_reg  <= rem_sub[63:0];
                    dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
                    q_reg    <= {q_reg[QW-2:0], rem_ge};
                    over_reg <= over_reg | q_reg[QW-1];
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == DC_W'(DVD_W - 1))
                        state_reg <= S_UWR;
                end

                S_UWR:
                begin
                    w_reg[i_reg] <= w_sat;
                    if (i_reg == FI_W'(N_FEATURES - 1))
                        state_reg <= S_NEXT;
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_URD;
                    end
                end

                S_NEXT:
                begin
                    i_reg    <= '0;
                    acc_reg  <= '0;
                    norm_reg <= '0;
                    if ((SC_W + 1)'(s_reg) + 1'b1 == (SC_W + 1)'(sc_reg))
                    begin
                        s_reg     <= '0;
                        sbase_reg <= '0;
                        ep_reg    <= ep_reg + 1'b1;
                        if ((EPOCH_W + 1)'(ep_reg) + 1'b1 == (EPOCH_W + 1)'(epoch_count_reg))
                            state_reg <= S_ELOAD;
                        else
                            state_reg <= S_DRD;
                    end
                    else
                    begin
                        s_reg     <= s_reg + 1'b1;
                        sbase_reg <= sbase_reg + SA_W'(N_FEATURES);
                        state_reg <= S_DRD;
                    end
                end

                S_ELOAD:
                begin
                    out_reg.result_value <= w_rd;
                    out_reg.weight_index <= 6'(i_reg);
                    out_reg.result_last  <= (i_reg == FI_W'(N_FEATURES - 1));
                    out_reg.status       <= dropped_reg ? ST_DROPPED : ST_OK;
                    out_valid_reg        <= 1'b1;
                    train_emit_reg       <= 1'b1;
                    state_reg            <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (!train_emit_reg)
                            state_reg <= S_IDLE;
                        else if (i_reg == FI_W'(N_FEATURES - 1))
                        begin
                            sc_reg      <= '0;
                            wbase_reg   <= '0;
                            dropped_reg <= 1'b0;
                            pos_reg     <= '0;
                            i_reg       <= '0;
                            state_reg   <= S_IDLE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_ELOAD;
                        end
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hdl/klnt_checker.sv -----
// port-level checks of the trainer, bound to the top level
`include "kaczmarz_linear_node_trainer_defines.svh"

module klnt_checker
    import klnt_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input in_t                in_data,
    input logic               out_valid,
    input logic               out_ready,
    input out_t               out_data
);

    // a stalled result stays put
    `KLNT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `KLNT_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data))

    // no new request while a result is pending
    `KLNT_ASSERT_NOW(a_busy_emit, clk, rst_n, out_valid, !in_ready)

    // a length error only comes as a lone prediction result
    `KLNT_ASSERT_NOW(a_len_err, clk, rst_n, out_valid && (out_data.status == ST_LEN_ERR),
        out_data.result_last && (out_data.weight_index == 6'd0))

    // a training request always keeps the block busy afterwards
    `KLNT_ASSERT_NEXT(a_train_busy, clk, rst_n,
        in_valid && in_ready && (in_data.operation == OP_TRAIN), !in_ready)

endmodule

bind kaczmarz_linear_node_trainer klnt_checker u_klnt_checker (.*);
